// ===== hdl/qau_pkg.sv =====
package qau_pkg;

  // Default word layout: signed Q16.16
  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned FracBitsDef  = 16;

  // Opcodes
  typedef enum logic [2:0] {
    OP_CONJ   = 3'd0,
    OP_MUL    = 3'd1,
    OP_INVMUL = 3'd2,
    OP_MULINV = 3'd3,
    OP_NORM   = 3'd4,
    OP_ROT    = 3'd5
  } op_e;

endpackage

// ===== hdl/quaternion_arithmetic_unit.sv =====
// Quaternion arithmetic unit, signed fixed point (Q16.16 by default).
// Input channel: valid_i / stall_o with op_i, a_*_i and b_*_i; a beat is
// taken at a rising edge with valid_i high and stall_o low.
// Output channel: valid_o / stall_i with r_*_o and saturated_o; a beat is
// delivered at an edge with valid_o high and stall_i low.
// Ops: conjugate, Hamilton product, product with a's or b's scalar negated,
// gain-0.5 normalizing filter, and rotation of vector b by a.
// Five register stages: input register, 4x4 product array, sum/clamp stage
// (filter correction or rotation matrix), second product array of nine
// multipliers, final sum/clamp into the output register, whose valid bit
// drives valid_o. One beat enters per cycle while stall_o is low.
// Reset clears all stage valid bits; the pipeline comes up empty.
// When the receiver stalls, the output holds; each stage keeps moving
// until it meets a full stage ahead, so bubbles are squeezed out, and
// stall_o rises only when every stage holds a beat.
module quaternion_arithmetic_unit
  import qau_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic [2:0]                   op_i,
  input  logic signed [DATA_WIDTH-1:0] a_w_i,
  input  logic signed [DATA_WIDTH-1:0] a_x_i,
  input  logic signed [DATA_WIDTH-1:0] a_y_i,
  input  logic signed [DATA_WIDTH-1:0] a_z_i,
  input  logic signed [DATA_WIDTH-1:0] b_w_i,
  input  logic signed [DATA_WIDTH-1:0] b_x_i,
  input  logic signed [DATA_WIDTH-1:0] b_y_i,
  input  logic signed [DATA_WIDTH-1:0] b_z_i,
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic signed [DATA_WIDTH-1:0] r_w_o,
  output logic signed [DATA_WIDTH-1:0] r_x_o,
  output logic signed [DATA_WIDTH-1:0] r_y_o,
  output logic signed [DATA_WIDTH-1:0] r_z_o,
  output logic                         saturated_o
);

  localparam int DW = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int XW = DW + 1;          // operand with room for a negated scalar
  localparam int PW = 2 * XW - F;      // first-array product after shift
  localparam int QW = 2 * DW - F;      // second-array product after shift
  localparam int EW = 2 * DW + 5 - F;  // sums and clamp inputs

  localparam logic signed [EW-1:0] HI_E   = {{(EW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [EW-1:0] LO_E   = ~HI_E;
  localparam logic signed [EW-1:0] ONE_E  = {{(EW-1-F){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [EW-1:0] HALF_E = {{(EW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

  // Clamp to the word range; top bit is the clamp flag
  function automatic logic [DW:0] sat_f(input logic signed [EW-1:0] x);
    logic [DW:0] res;
    if (x > HI_E) begin
      res = {1'b1, HI_E[DW-1:0]};
    end else if (x < LO_E) begin
      res = {1'b1, LO_E[DW-1:0]};
    end else begin
      res = {1'b0, x[DW-1:0]};
    end
    return res;
  endfunction

  // Stage valid bits and enables
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5     = !v5_q || !stall_i;
  assign en4     = !v4_q || en5;
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign stall_o = !en1;
  assign valid_o = v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // Stage 1: input register
  op_e                  op1_q;
  logic signed [DW-1:0] a1_q [4];
  logic signed [DW-1:0] b1_q [4];

  always_ff @(posedge clk_i) begin
    if (en1) begin
      op1_q   <= op_e'(op_i);
      a1_q[0] <= a_w_i;
      a1_q[1] <= a_x_i;
      a1_q[2] <= a_y_i;
      a1_q[3] <= a_z_i;
      b1_q[0] <= b_w_i;
      b1_q[1] <= b_x_i;
      b1_q[2] <= b_y_i;
      b1_q[3] <= b_z_i;
    end
  end

  // Stage 2: 4x4 product array, x = a (scalar maybe negated), y = b or a
  logic signed [XW-1:0]   x_s [4];
  logic signed [XW-1:0]   y_s [4];
  logic signed [2*XW-1:0] prod1 [4][4];
  logic signed [PW-1:0]   pr2_d [4][4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      x_s[k] = XW'(a1_q[k]);
      if (op1_q == OP_NORM || op1_q == OP_ROT) begin
        y_s[k] = XW'(a1_q[k]);
      end else begin
        y_s[k] = XW'(b1_q[k]);
      end
    end
    if (op1_q == OP_INVMUL) x_s[0] = -XW'(a1_q[0]);
    if (op1_q == OP_MULINV) y_s[0] = -XW'(b1_q[0]);
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod1[i][j] = x_s[i] * y_s[j];
        pr2_d[i][j] = $signed(prod1[i][j][2*XW-1:F]);
      end
    end
  end

  op_e                  op2_q;
  logic signed [DW-1:0] a2_q [4];
  logic signed [DW-1:0] b2_q [4];
  logic signed [PW-1:0] pr2_q [4][4];

  always_ff @(posedge clk_i) begin
    if (en2) begin
      op2_q <= op1_q;
      a2_q  <= a1_q;
      b2_q  <= b1_q;
      pr2_q <= pr2_d;
    end
  end

  // Stage 3: product sums, filter correction, rotation matrix
  logic signed [EW-1:0] p [4][4];
  logic signed [EW-1:0] s3_d [4];
  logic signed [EW-1:0] m_e [9];
  logic signed [EW-1:0] d_e;
  logic signed [DW-1:0] c3_d [9];
  logic                 flag3_d;
  logic [DW:0]          sat3;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p[i][j] = EW'(pr2_q[i][j]);
      end
    end
    s3_d[0] = p[0][0] - p[1][1] - p[2][2] - p[3][3];
    s3_d[1] = p[0][1] + p[1][0] + p[2][3] - p[3][2];
    s3_d[2] = p[0][2] - p[1][3] + p[2][0] + p[3][1];
    s3_d[3] = p[0][3] + p[1][2] - p[2][1] + p[3][0];
    // rotation matrix, row-major
    m_e[0] = p[0][0] + p[1][1] - HALF_E;
    m_e[4] = p[0][0] + p[2][2] - HALF_E;
    m_e[8] = p[0][0] + p[3][3] - HALF_E;
    m_e[3] = p[1][2] + p[0][3];
    m_e[1] = p[1][2] - p[0][3];
    m_e[2] = p[1][3] + p[0][2];
    m_e[6] = p[1][3] - p[0][2];
    m_e[7] = p[2][3] + p[0][1];
    m_e[5] = p[2][3] - p[0][1];
    d_e    = ONE_E - (p[0][0] + p[1][1] + p[2][2] + p[3][3]);
    flag3_d = 1'b0;
    for (int k = 0; k < 9; k++) begin
      c3_d[k] = '0;
    end
    case (op2_q)
      OP_NORM: begin
        sat3    = sat_f(d_e >>> 1);
        c3_d[0] = $signed(sat3[DW-1:0]);
        flag3_d = sat3[DW];
      end
      OP_ROT: begin
        sat3 = '0;
        for (int k = 0; k < 9; k++) begin
          sat3    = sat_f(m_e[k]);
          c3_d[k] = $signed(sat3[DW-1:0]);
          flag3_d = flag3_d | sat3[DW];
        end
      end
      default: begin
        sat3 = '0;
      end
    endcase
  end

  op_e                  op3_q;
  logic signed [DW-1:0] a3_q [4];
  logic signed [DW-1:0] b3_q [4];
  logic signed [EW-1:0] s3_q [4];
  logic signed [DW-1:0] c3_q [9];
  logic                 flag3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      op3_q   <= op2_q;
      a3_q    <= a2_q;
      b3_q    <= b2_q;
      s3_q    <= s3_d;
      c3_q    <= c3_d;
      flag3_q <= flag3_d;
    end
  end

  // Stage 4: second product array (a * corr, or matrix * vector)
  logic signed [DW-1:0]   mx [9];
  logic signed [DW-1:0]   my [9];
  logic signed [2*DW-1:0] prod2 [9];
  logic signed [QW-1:0]   q4_d [9];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      if (op3_q == OP_ROT || k >= 4) begin
        mx[k] = c3_q[k];
        my[k] = b3_q[(k % 3) + 1];
      end else begin
        mx[k] = a3_q[k];
        my[k] = c3_q[0];
      end
      prod2[k] = mx[k] * my[k];
      q4_d[k]  = $signed(prod2[k][2*DW-1:F]);
    end
  end

  op_e                  op4_q;
  logic signed [DW-1:0] a4_q [4];
  logic signed [EW-1:0] s4_q [4];
  logic signed [QW-1:0] q4_q [9];
  logic                 flag4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      op4_q   <= op3_q;
      a4_q    <= a3_q;
      s4_q    <= s3_q;
      q4_q    <= q4_d;
      flag4_q <= flag3_q;
    end
  end

  // Stage 5: final sums, clamp into output register
  logic signed [EW-1:0] r_e [4];
  logic signed [DW-1:0] r5_d [4];
  logic                 flag5_d;
  logic [DW:0]          sat5;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      r_e[k] = '0;
    end
    case (op4_q)
      OP_CONJ: begin
        r_e[0] = EW'(a4_q[0]);
        for (int k = 1; k < 4; k++) begin
          r_e[k] = -EW'(a4_q[k]);
        end
      end
      OP_MUL, OP_INVMUL, OP_MULINV: begin
        r_e = s4_q;
      end
      OP_NORM: begin
        for (int k = 0; k < 4; k++) begin
          r_e[k] = EW'(a4_q[k]) + EW'(q4_q[k]);
        end
      end
      OP_ROT: begin
        for (int k = 1; k < 4; k++) begin
          r_e[k] = (EW'(q4_q[3*k-3]) + EW'(q4_q[3*k-2]) + EW'(q4_q[3*k-1])) <<< 1;
        end
      end
      default: begin
        r_e[0] = '0;
      end
    endcase
    flag5_d = flag4_q;
    sat5    = '0;
    for (int k = 0; k < 4; k++) begin
      sat5    = sat_f(r_e[k]);
      r5_d[k] = $signed(sat5[DW-1:0]);
      flag5_d = flag5_d | sat5[DW];
    end
  end

  op_e                  op5_q;
  logic signed [DW-1:0] r5_q [4];
  logic                 flag5_q;

  always_ff @(posedge clk_i) begin
    if (en5) begin
      op5_q   <= op4_q;
      r5_q    <= r5_d;
      flag5_q <= flag5_d;
    end
  end

  assign r_w_o       = r5_q[0];
  assign r_x_o       = r5_q[1];
  assign r_y_o       = r5_q[2];
  assign r_z_o       = r5_q[3];
  assign saturated_o = flag5_q;

  // Checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (v1_q && v2_q && v3_q && v4_q && v5_q && stall_i))
    else $error("input stalled while pipeline has room");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && op5_q == OP_ROT) |-> (r_w_o == '0))
    else $error("rotate result has nonzero scalar");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && stall_i) |=> (v5_q && $stable(flag5_q) && $stable(op5_q)))
    else $error("held result changed under stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !(op5_q == OP_CONJ || op5_q == OP_MUL || op5_q == OP_INVMUL ||
      op5_q == OP_MULINV || op5_q == OP_NORM || op5_q == OP_ROT))
    |-> (r_x_o == '0 && r_y_o == '0 && r_z_o == '0 && !saturated_o))
    else $error("unused opcode gave nonzero result");

endmodule

// ===== bench/tb_quaternion_arithmetic_unit.sv =====
`timescale 1ns / 100ps

module tb_quaternion_arithmetic_unit;
  import qau_pkg::*;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int MAX_IDLE = 16;

  typedef logic signed [DW-1:0] word_t;

  typedef struct packed {
    logic [2:0] op;
    word_t a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z;
  } qop_t;

  typedef struct packed {
    word_t r_w, r_x, r_y, r_z;
    logic  sat;
  } qres_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_o;
  logic [2:0] op_i = '0;
  word_t a_w_i = '0, a_x_i = '0, a_y_i = '0, a_z_i = '0;
  word_t b_w_i = '0, b_x_i = '0, b_y_i = '0, b_z_i = '0;
  logic valid_o;
  logic stall_i = 1'b0;
  word_t r_w_o, r_x_o, r_y_o, r_z_o;
  logic saturated_o;

  qres_t expected_q[$];
  int mismatches = 0;
  int beats_out = 0;
  int beats_in = 0;
  int sat_seen = 0;
  bit sink_quiet = 1'b0;

  quaternion_arithmetic_unit DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Fixed-point helpers; products are formed in 128-bit signed to stay exact
  function automatic longint fx_mul(longint x, longint y);
    logic signed [127:0] p;
    p = x * y;
    return longint'(p >>> FB);
  endfunction

  function automatic longint fx_clamp(longint x, ref bit flag);
    longint hi, lo;
    hi = (longint'(1) <<< (DW - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) begin
      flag = 1'b1;
      return hi;
    end
    if (x < lo) begin
      flag = 1'b1;
      return lo;
    end
    return x;
  endfunction

  function automatic qres_t quat_predict(qop_t q);
    longint aw, ax, ay, az, bw, bx, by, bz, pw, qw, sq, d, corr, s, t, u;
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
    longint r[4];
    bit flag;
    qres_t res;
    aw = q.a_w; ax = q.a_x; ay = q.a_y; az = q.a_z;
    bw = q.b_w; bx = q.b_x; by = q.b_y; bz = q.b_z;
    r = '{0, 0, 0, 0};
    flag = 1'b0;
    case (q.op)
      OP_CONJ: begin
        r[0] = aw; r[1] = -ax; r[2] = -ay; r[3] = -az;
      end
      OP_MUL, OP_INVMUL, OP_MULINV: begin
        pw = (q.op == OP_INVMUL) ? -aw : aw;
        qw = (q.op == OP_MULINV) ? -bw : bw;
        r[0] = fx_mul(pw, qw) - fx_mul(ax, bx) - fx_mul(ay, by) - fx_mul(az, bz);
        r[1] = fx_mul(pw, bx) + fx_mul(ax, qw) + fx_mul(ay, bz) - fx_mul(az, by);
        r[2] = fx_mul(pw, by) - fx_mul(ax, bz) + fx_mul(ay, qw) + fx_mul(az, bx);
        r[3] = fx_mul(pw, bz) + fx_mul(ax, by) - fx_mul(ay, bx) + fx_mul(az, qw);
      end
      OP_NORM: begin
        sq = fx_mul(aw, aw) + fx_mul(ax, ax) + fx_mul(ay, ay) + fx_mul(az, az);
        d = (longint'(1) <<< FB) - sq;
        corr = fx_clamp(d >>> 1, flag);
        r[0] = aw + fx_mul(aw, corr);
        r[1] = ax + fx_mul(ax, corr);
        r[2] = ay + fx_mul(ay, corr);
        r[3] = az + fx_mul(az, corr);
      end
      OP_ROT: begin
        s = fx_mul(aw, aw);
        m00 = fx_clamp(s + fx_mul(ax, ax) - (longint'(1) <<< (FB - 1)), flag);
        m11 = fx_clamp(s + fx_mul(ay, ay) - (longint'(1) <<< (FB - 1)), flag);
        m22 = fx_clamp(s + fx_mul(az, az) - (longint'(1) <<< (FB - 1)), flag);
        t = fx_mul(aw, az); u = fx_mul(ax, ay);
        m10 = fx_clamp(u + t, flag); m01 = fx_clamp(u - t, flag);
        t = fx_mul(aw, ay); u = fx_mul(ax, az);
        m02 = fx_clamp(u + t, flag); m20 = fx_clamp(u - t, flag);
        t = fx_mul(aw, ax); u = fx_mul(ay, az);
        m21 = fx_clamp(u + t, flag); m12 = fx_clamp(u - t, flag);
        r[1] = 2 * (fx_mul(m00, bx) + fx_mul(m01, by) + fx_mul(m02, bz));
        r[2] = 2 * (fx_mul(m10, bx) + fx_mul(m11, by) + fx_mul(m12, bz));
        r[3] = 2 * (fx_mul(m20, bx) + fx_mul(m21, by) + fx_mul(m22, bz));
      end
      default: ;
    endcase
    res.r_w = word_t'(fx_clamp(r[0], flag));
    res.r_x = word_t'(fx_clamp(r[1], flag));
    res.r_y = word_t'(fx_clamp(r[2], flag));
    res.r_z = word_t'(fx_clamp(r[3], flag));
    res.sat = flag;
    return res;
  endfunction

  // Send one beat after a random idle gap; prediction queued on acceptance
  task automatic send_beat(qop_t q, bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, MAX_IDLE);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    op_i <= q.op;
    a_w_i <= q.a_w; a_x_i <= q.a_x; a_y_i <= q.a_y; a_z_i <= q.a_z;
    b_w_i <= q.b_w; b_x_i <= q.b_x; b_y_i <= q.b_y; b_z_i <= q.b_z;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    expected_q.push_back(quat_predict(q));
    beats_in++;
  endtask

  task automatic release_input();
    valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random operand: full range, small Q16.16 values, or corner values
  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0: return word_t'($urandom);
      1: return word_t'({DW{1'b1}} >> 1);
      2: return word_t'(1) <<< (DW - 1);
      3: return word_t'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      default: return word_t'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic qop_t rand_op(logic [2:0] op);
    qop_t q;
    q.op = op;
    q.a_w = rand_word(); q.a_x = rand_word(); q.a_y = rand_word(); q.a_z = rand_word();
    q.b_w = rand_word(); q.b_x = rand_word(); q.b_y = rand_word(); q.b_z = rand_word();
    return q;
  endfunction

  // Corners and special cases
  task automatic test_directed();
    qop_t q;
    word_t mx, mn, one;
    mx = word_t'({DW{1'b1}} >> 1);
    mn = word_t'(1) <<< (DW - 1);
    one = word_t'(1) <<< FB;
    // conjugate of most negative, and of max/zero
    send_beat('{OP_CONJ, mn, mn, mx, 0, 0, 0, 0, 0});
    send_beat('{OP_CONJ, mx, 0, mn, -1, -1, -1, -1, -1});
    // identity products and extreme products
    send_beat('{OP_MUL, one, 0, 0, 0, 3, -5, 7, -9});
    send_beat('{OP_MUL, mx, mx, mx, mx, mx, mx, mx, mx});
    send_beat('{OP_MUL, mn, mn, mn, mn, mn, mn, mn, mn});
    // negated scalar kept wide: most negative scalar
    send_beat('{OP_INVMUL, mn, 0, 0, 0, one, 0, 0, 0});
    send_beat('{OP_INVMUL, mn, mx, mn, mx, mn, mx, mn, mx});
    send_beat('{OP_MULINV, one, 0, 0, 0, mn, 0, 0, 0});
    send_beat('{OP_MULINV, mx, mn, mx, mn, mx, mn, mx, mn});
    // filter: unit, zero, huge (correction clamps)
    send_beat('{OP_NORM, one, 0, 0, 0, 0, 0, 0, 0});
    send_beat('{OP_NORM, 0, 0, 0, 0, 0, 0, 0, 0});
    send_beat('{OP_NORM, mx, mx, mn, mn, 0, 0, 0, 0});
    send_beat('{OP_NORM, one >>> 1, one >>> 1, one >>> 1, one >>> 1, 0, 0, 0, 0});
    // rotation: identity, matrix clamp, extreme vector
    send_beat('{OP_ROT, one, 0, 0, 0, mx, one, -one, 2 * one});
    send_beat('{OP_ROT, mx, mn, mx, mn, 0, mx, mn, mx});
    send_beat('{OP_ROT, 0, one, 0, 0, 0, mx, mx, mn});
    // unused opcodes
    send_beat('{3'd6, mx, mx, mx, mx, mx, mx, mx, mx});
    send_beat('{3'd7, mn, mn, mn, mn, mn, mn, mn, mn});
    q = '1;
    send_beat(q);
    send_beat('0);
    release_input();
  endtask

  // Random traffic, mostly legal opcodes
  task automatic test_random(int n);
    logic [2:0] op;
    repeat (n) begin
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      send_beat(rand_op(op), $urandom_range(0, 3) == 0);
    end
    release_input();
  endtask

  // Back to back burst, then hold off until the pipeline drains
  task automatic test_burst_drain();
    sink_quiet = 1'b1;
    repeat (40) send_beat(rand_op(3'($urandom_range(0, 5))), 1'b1);
    release_input();
    sink_quiet = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Output side: random stall per beat, checks at each accepted beat
  initial begin : sink
    int wait_n;
    qres_t exp_r;
    forever begin
      wait_n = sink_quiet ? 0 : $urandom_range(0, MAX_IDLE);
      if ($urandom_range(0, 2) == 0) wait_n = 0;
      if (wait_n > 0) begin
        stall_i <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
      end
      stall_i <= 1'b0;
      @(posedge clk_i);
      // unknown valid before the first reset edge counts as idle
      while (valid_o !== 1'b1) @(posedge clk_i);
      beats_out++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat r=%h %h %h %h sat=%b", $time,
                 r_w_o, r_x_o, r_y_o, r_z_o, saturated_o);
        mismatches++;
      end else begin
        exp_r = expected_q.pop_front();
        if (exp_r.sat) sat_seen++;
        if ({r_w_o, r_x_o, r_y_o, r_z_o, saturated_o} !== exp_r) begin
          $display("%0t: result mismatch exp w=%h x=%h y=%h z=%h sat=%b", $time,
                   exp_r.r_w, exp_r.r_x, exp_r.r_y, exp_r.r_z, exp_r.sat);
          $display("%0t:                 got w=%h x=%h y=%h z=%h sat=%b", $time,
                   r_w_o, r_x_o, r_y_o, r_z_o, saturated_o);
          mismatches++;
        end
      end
    end
  end

  initial begin : main
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_burst_drain();
    test_random(1200);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d beats across all opcodes, checked %0d results (%0d saturated).",
             beats_in, beats_out, sat_seen);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
